>>> rtl/srlp_pkg.sv
`timescale 1ns / 1ps

package srlp_pkg;

   // widths
   localparam int ByteWidth  = 8;
   localparam int LevelWidth = 8;
   localparam int MagWidth   = 9;
   localparam int ChanWidth  = 2;
   localparam int PhaseWidth = 2;
   localparam int NumChans   = 3;

   // character codes
   localparam logic [ByteWidth-1:0] CrByte    = 8'd13;
   localparam logic [ByteWidth-1:0] TabByte   = 8'd9;
   localparam logic [ByteWidth-1:0] FeedByte  = 8'd12;
   localparam logic [ByteWidth-1:0] SpaceByte = 8'd32;
   localparam logic [ByteWidth-1:0] PlusByte  = 8'd43;
   localparam logic [ByteWidth-1:0] MinusByte = 8'd45;
   localparam logic [ByteWidth-1:0] ZeroByte  = 8'd48;
   localparam logic [ByteWidth-1:0] NineByte  = 8'd57;

   // magnitude saturation point, one above the largest level
   localparam logic [MagWidth-1:0] MagSat = 9'd256;

   // parse phases
   localparam logic [PhaseWidth-1:0] PhSkip   = 2'd0;
   localparam logic [PhaseWidth-1:0] PhSign   = 2'd1;
   localparam logic [PhaseWidth-1:0] PhDigits = 2'd2;
   localparam logic [PhaseWidth-1:0] PhDone   = 2'd3;

   // channels
   localparam logic [ChanWidth-1:0] ChRed   = 2'd0;
   localparam logic [ChanWidth-1:0] ChGreen = 2'd1;
   localparam logic [ChanWidth-1:0] ChBlue  = 2'd2;

   typedef struct packed {
      logic                  accepted;
      logic [ChanWidth-1:0]  channel;
      logic [LevelWidth-1:0] parsed_level;
      logic                  apply;
      logic [LevelWidth-1:0] red_level;
      logic [LevelWidth-1:0] green_level;
      logic [LevelWidth-1:0] blue_level;
   } srlp_result_type;

endpackage

>>> rtl/srlp_req_if.sv
`timescale 1ns / 1ps

interface srlp_req_if import srlp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/srlp_rsp_if.sv
`timescale 1ns / 1ps

interface srlp_rsp_if import srlp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  accepted;
   logic [ChanWidth-1:0]  channel;
   logic [LevelWidth-1:0] parsed_level;
   logic                  apply;
   logic [LevelWidth-1:0] red_level;
   logic [LevelWidth-1:0] green_level;
   logic [LevelWidth-1:0] blue_level;

   modport source (output valid, output accepted, output channel, output parsed_level,
                   output apply, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink (input valid, input accepted, input channel, input parsed_level,
                 input apply, input red_level, input green_level,
                 input blue_level, output ready);
endinterface

>>> rtl/srlp_in_stage.sv
`timescale 1ns / 1ps

module srlp_in_stage import srlp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   srlp_req_if.sink             req_if,
   input  logic                 advance,
   output logic                 item_valid,
   output logic [ByteWidth-1:0] item_byte
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [ByteWidth-1:0] byte_ff;
   logic                 take;

   // room when empty or when the held request moves on this cycle
   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // request byte holding register
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_if.rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

>>> rtl/srlp_parse.sv
`timescale 1ns / 1ps

module srlp_parse import srlp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [ByteWidth-1:0] item_byte,
   output logic                 is_cr,
   output srlp_result_type      result
);

   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [MagWidth-1:0]   mag_ff, mag_in;
   logic [ChanWidth-1:0]  chan_ff, chan_in;
   logic [LevelWidth-1:0] levels_ff [NumChans];
   logic [LevelWidth-1:0] levels_in [NumChans];

   logic                  is_space;
   logic                  is_digit;
   logic [3:0]            digit;
   logic [11:0]           prod;
   logic [MagWidth-1:0]   mag_digit;
   logic [ChanWidth-1:0]  ch;
   logic                  ok;
   logic                  apply;

   // character classes
   assign is_cr    = (item_byte == CrByte);
   assign is_space = (item_byte == SpaceByte) ||
                     ((item_byte >= TabByte) && (item_byte <= FeedByte));
   assign is_digit = (item_byte >= ZeroByte) && (item_byte <= NineByte);
   assign digit    = 4'(item_byte - ZeroByte);

   // magnitude times ten plus digit, saturated
   assign prod      = ({3'b000, mag_ff} << 3) + ({3'b000, mag_ff} << 1) + {8'h00, digit};
   assign mag_digit = (prod > {3'b000, MagSat}) ? MagSat : prod[MagWidth-1:0];

   // line end check
   assign ch    = (chan_ff == 2'd3) ? ChBlue : chan_ff;
   assign ok    = !mag_ff[MagWidth-1] && !(neg_ff && (mag_ff != '0));
   assign apply = ok && (ch == ChBlue);

   // next parse and level state
   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      chan_in   = chan_ff;
      levels_in = levels_ff;
      if (is_cr) begin
         phase_in = PhSkip;
         neg_in   = 1'b0;
         mag_in   = '0;
         if (ok) begin
            levels_in[ch] = mag_ff[LevelWidth-1:0];
            chan_in       = apply ? ChRed : ch + 2'd1;
         end
      end else begin
         unique case (phase_ff)
            PhSkip: begin
               priority if (is_space) begin
                  phase_in = PhSkip;
               end else if (item_byte == PlusByte) begin
                  phase_in = PhSign;
               end else if (item_byte == MinusByte) begin
                  neg_in   = 1'b1;
                  phase_in = PhSign;
               end else if (is_digit) begin
                  mag_in   = {5'b00000, digit};
                  phase_in = PhDigits;
               end else begin
                  phase_in = PhDone;
               end
            end
            PhSign, PhDigits: begin
               if (is_digit) begin
                  mag_in   = mag_digit;
                  phase_in = PhDigits;
               end else begin
                  phase_in = PhDone;
               end
            end
            PhDone: begin
               phase_in = PhDone;
            end
            default: begin
               phase_in = PhDone;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PhSkip;
         neg_ff    <= 1'b0;
         mag_ff    <= '0;
         chan_ff   <= ChRed;
         levels_ff <= '{default: '0};
      end else if (step) begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         mag_ff    <= mag_in;
         chan_ff   <= chan_in;
         levels_ff <= levels_in;
      end
   end

   // response for a line end, levels as they stand after it
   always_comb begin
      result.accepted     = ok;
      result.channel      = ch;
      result.parsed_level = ok ? mag_ff[LevelWidth-1:0] : '0;
      result.apply        = apply;
      result.red_level    = levels_in[0];
      result.green_level  = levels_in[1];
      result.blue_level   = levels_in[2];
   end

`ifndef SYNTHESIS
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      mag_ff <= MagSat)
      else $error("magnitude above saturation");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      chan_ff != 2'd3)
      else $error("channel index out of range");

   a_cr_clears: assert property (@(posedge clock) disable iff (reset)
      step && is_cr |=> (phase_ff == PhSkip) && !neg_ff && (mag_ff == '0))
      else $error("line end did not clear parse state");

   a_levels_hold: assert property (@(posedge clock) disable iff (reset)
      step && !is_cr |=> $stable(chan_ff) && $stable(levels_ff[0]) &&
                         $stable(levels_ff[1]) && $stable(levels_ff[2]))
      else $error("levels changed without a line end");

   a_apply_wraps: assert property (@(posedge clock) disable iff (reset)
      step && is_cr && apply |=> chan_ff == ChRed)
      else $error("channel did not wrap after apply");
`endif

endmodule

>>> rtl/srlp_out_stage.sv
`timescale 1ns / 1ps

module srlp_out_stage import srlp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  srlp_result_type result,
   output logic            out_free,
   srlp_rsp_if.source      rsp_if
);

   logic            valid_ff;
   logic            valid_in;
   srlp_result_type data_ff;

   // slot frees when empty or taken this cycle
   assign out_free = !valid_ff || rsp_if.ready;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   // drive response channel
   assign rsp_if.valid        = valid_ff;
   assign rsp_if.accepted     = data_ff.accepted;
   assign rsp_if.channel      = data_ff.channel;
   assign rsp_if.parsed_level = data_ff.parsed_level;
   assign rsp_if.apply        = data_ff.apply;
   assign rsp_if.red_level    = data_ff.red_level;
   assign rsp_if.green_level  = data_ff.green_level;
   assign rsp_if.blue_level   = data_ff.blue_level;

endmodule

>>> rtl/serial_rgb_level_parser.sv
`timescale 1ns / 1ps
// serial rgb level parser
// req_if carries one received character per request (rx_byte). Each line
// ending in carriage return is parsed as a signed decimal number; a value
// 0..255 sets the current channel's level (red, green, blue in turn) and
// advances the channel, anything else is rejected and the channel repeats.
// rsp_if carries one response per carriage return: accepted, channel,
// parsed_level, apply (blue accepted) and the three stored levels.
// Characters other than carriage return give no response.
// Throughput: one request per cycle while no carriage return waits on a full
// response register; the parse logic between the two registers is combinational.
// A carriage return is held in the input register, then its response in the
// response register, which it enters once that register frees.
// Reset (synchronous, active high) empties both registers, selects red,
// clears all levels and the parse state.
// A stalled rsp_if holds the response; characters that are not carriage
// returns keep flowing, and a carriage return waits in the input register
// until the response register frees, holding req_if.ready low meanwhile.
module serial_rgb_level_parser import srlp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   srlp_req_if.sink   req_if,
   srlp_rsp_if.source rsp_if
);

   logic                 item_valid;
   logic [ByteWidth-1:0] item_byte;
   logic                 is_cr;
   logic                 out_free;
   logic                 advance;
   logic                 load;
   srlp_result_type      result;

   // a character moves on unless it is a line end facing a full response slot
   assign advance = item_valid && (!is_cr || out_free);
   assign load    = advance && is_cr;

   srlp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   srlp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item_byte (item_byte),
      .is_cr     (is_cr),
      .result    (result)
   );

   srlp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .result   (result),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

endmodule

>>> sim/serial_rgb_level_parser_checker.sv
`timescale 1ns / 1ps

module serial_rgb_level_parser_checker import srlp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   srlp_req_if         req_mon,
   srlp_rsp_if         rsp_mon,
   output int unsigned error_count,
   output int unsigned pending_count
);

   localparam logic [MagWidth-1:0] MaxLevel = MagSat - 1'b1;

   // shadow copy of the parser state
   logic [ChanWidth-1:0]  chan_sel;
   logic [LevelWidth-1:0] level_store [NumChans];
   logic [PhaseWidth-1:0] phase;
   logic                  minus_seen;
   logic [MagWidth-1:0]   mag;

   srlp_result_type expected_lines [$];
   int unsigned     fail_total;

   function automatic bit is_digit(input logic [ByteWidth-1:0] c);
      return c >= ZeroByte && c <= NineByte;
   endfunction

   // append one decimal digit, saturating at one above the largest level
   function automatic logic [MagWidth-1:0] add_digit(input logic [MagWidth-1:0] m,
                                                      input logic [ByteWidth-1:0] c);
      int v;
      v = int'(m) * 10 + int'(c - ZeroByte);
      return (v > int'(MagSat)) ? MagSat : v[MagWidth-1:0];
   endfunction

   task automatic clear_line();
      phase      = PhSkip;
      minus_seen = 1'b0;
      mag        = '0;
   endtask

   // advance the parse by one character; a carriage return yields a line result
   task automatic parse_char(input logic [ByteWidth-1:0] c, output bit has_line,
                             output srlp_result_type line);
      logic [ChanWidth-1:0] ch;
      bit                   ok;
      has_line = 1'b0;
      line     = '0;
      if (c != CrByte) begin
         case (phase)
            PhSkip: begin
               if (!(c == SpaceByte || (c >= TabByte && c <= FeedByte))) begin
                  if (c == PlusByte) begin
                     phase = PhSign;
                  end else if (c == MinusByte) begin
                     minus_seen = 1'b1;
                     phase      = PhSign;
                  end else if (is_digit(c)) begin
                     mag   = add_digit('0, c);
                     phase = PhDigits;
                  end else begin
                     phase = PhDone;
                  end
               end
            end
            PhSign, PhDigits: begin
               if (is_digit(c)) begin
                  mag   = add_digit(mag, c);
                  phase = PhDigits;
               end else begin
                  phase = PhDone;
               end
            end
            default: begin
            end
         endcase
      end else begin
         // end of line: validate and store for the current channel
         ch = (chan_sel > ChBlue) ? ChBlue : chan_sel;
         ok = (mag <= MaxLevel) && !(minus_seen && mag != '0);
         line.accepted = ok;
         line.channel  = ch;
         if (ok) begin
            level_store[ch]   = mag[LevelWidth-1:0];
            line.parsed_level = mag[LevelWidth-1:0];
            if (ch == ChBlue) begin
               line.apply = 1'b1;
               chan_sel   = ChRed;
            end else begin
               chan_sel = ch + 1'b1;
            end
         end
         line.red_level   = level_store[ChRed];
         line.green_level = level_store[ChGreen];
         line.blue_level  = level_store[ChBlue];
         has_line = 1'b1;
         clear_line();
      end
   endtask

   task automatic check_field(input string name, input logic [LevelWidth-1:0] want,
                              input logic [LevelWidth-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_total++;
      end
   endtask

   // watch both channels, compare responses before taking the new request
   always @(posedge clock) begin
      bit              has_line;
      srlp_result_type line;
      srlp_result_type want;
      if (reset) begin
         chan_sel = ChRed;
         foreach (level_store[i]) level_store[i] = '0;
         clear_line();
         expected_lines.delete();
         fail_total = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_lines.size() == 0) begin
               $error("response with no line pending");
               fail_total++;
            end else begin
               want = expected_lines.pop_front();
               check_field("accepted", want.accepted, rsp_mon.accepted);
               check_field("channel", want.channel, rsp_mon.channel);
               check_field("parsed_level", want.parsed_level, rsp_mon.parsed_level);
               check_field("apply", want.apply, rsp_mon.apply);
               check_field("red_level", want.red_level, rsp_mon.red_level);
               check_field("green_level", want.green_level, rsp_mon.green_level);
               check_field("blue_level", want.blue_level, rsp_mon.blue_level);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_char(req_mon.rx_byte, has_line, line);
            if (has_line) expected_lines.push_back(line);
         end
      end
      error_count   <= fail_total;
      pending_count <= expected_lines.size();
   end

endmodule

>>> sim/serial_rgb_level_parser_tb.sv
`timescale 1ns / 1ps

module serial_rgb_level_parser_tb import srlp_pkg::*; ();

   localparam int ItemTarget  = 1750;
   localparam int HoldCycles  = 400;
   localparam int WatchLimit  = 4000;
   localparam int TailCycles  = 8;
   localparam logic [ByteWidth-1:0] LineFeed = 8'd10;
   localparam logic [ByteWidth-1:0] VTab     = 8'd11;

   logic clock;
   logic reset;

   srlp_req_if req_if ();
   srlp_rsp_if rsp_if ();

   int unsigned error_count;
   int unsigned pending_count;
   int          quiet_cycles;
   int          sent;
   int          burst_left;
   bit          steady;
   bit          hold_rsp;

   serial_rgb_level_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   serial_rgb_level_parser_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
   end
   always #4 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // fail if nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // response side: stall modes that change every so often, plus one long hold-off
   initial begin : rsp_stall
      int mode;
      int span;
      int tick;
      mode = 0;
      span = 0;
      tick = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(20, 200);
            end
            span--;
            tick++;
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= ((tick % 5) != 0);
            endcase
         end
      end
   end

   task automatic idle(input int n);
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // offer one character, in bursts separated by random gaps
   task automatic send_char(input logic [ByteWidth-1:0] c);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady) idle($urandom_range(0, 12));
      end
      burst_left--;
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= c;
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   // stop sending until every expected line result has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (TailCycles) @(posedge clock);
   endtask

   function automatic logic [ByteWidth-1:0] noise_byte();
      logic [ByteWidth-1:0] c;
      do c = $urandom_range(0, 255); while (c == CrByte);
      return c;
   endfunction

   // mostly well-formed numbers with blanks, signs and leading zeros; some noise
   task automatic send_random_line();
      logic [ByteWidth-1:0] blanks [5];
      int                   v;
      string                digits;
      blanks = '{TabByte, LineFeed, VTab, FeedByte, SpaceByte};
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(0, 8)) send_char(noise_byte());
      end else begin
         repeat ($urandom_range(0, 2)) send_char(blanks[$urandom_range(0, 4)]);
         case ($urandom_range(0, 7))
            0:       send_char(PlusByte);
            1:       send_char(MinusByte);
            default: begin
            end
         endcase
         case ($urandom_range(0, 9))
            0:       v = $urandom_range(256, 99999);
            1:       v = -1;
            2:       v = $urandom_range(0, 1) * 255;
            default: v = $urandom_range(0, 255);
         endcase
         if (v >= 0) begin
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_char(ZeroByte);
            digits = $sformatf("%0d", v);
            for (int i = 0; i < digits.len(); i++) send_char(digits[i]);
         end
         if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) send_char(noise_byte());
      end
      send_char(CrByte);
   endtask

   // request stimulus and verdict
   initial begin
      logic [ByteWidth-1:0] directed [$];
      bit                   hold_done;
      bit                   paused;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      sent       = 0;
      burst_left = 0;
      steady     = 1'b0;
      hold_rsp   = 1'b0;
      hold_done  = 1'b0;
      paused     = 1'b0;
      @(negedge reset);
      @(posedge clock);

      // empty line, largest level, minus zero (blue apply), saturating number,
      // blanks with sign and trailing text, zero byte ahead of the number,
      // all-ones byte ending the number
      directed = '{CrByte,
                   "2", "5", "5", CrByte,
                   MinusByte, "0", CrByte,
                   "3", "0", "0", CrByte,
                   TabByte, FeedByte, PlusByte, "7", "x", "9", CrByte,
                   8'h00, "1", CrByte,
                   "4", 8'hFF, "2", CrByte};
      foreach (directed[i]) send_char(directed[i]);
      drain();

      while (sent < ItemTarget) begin
         steady = (sent >= 300 && sent < 500) || (sent >= 800 && sent < 1100);
         if (!hold_done && sent >= 800) begin
            hold_rsp  = 1'b1;
            hold_done = 1'b1;
         end
         if (!paused && sent >= 1200) begin
            paused = 1'b1;
            drain();
         end
         send_random_line();
      end
      drain();

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
